/* hdl/ecu_pkg.sv */
`default_nettype none

package ecu_pkg;

  // Datapath widths.
  localparam int XYW  = 33;  // CORDIC x and y, and operands of the shared multiplier
  localparam int ZW   = 30;  // CORDIC angle, degrees with 20 fraction bits
  localparam int NW   = 25;  // rounded vector component before normalization
  localparam int L2W  = 48;  // squared length
  localparam int LENW = 25;  // vector length
  localparam int VW   = 16;  // Q1.14 vector component
  localparam int PW   = 32;  // Q23.8 position

  localparam logic signed [ZW-1:0]  DEG90    = 30'sd94371840;
  localparam logic signed [ZW-1:0]  DEG180   = 30'sd188743680;
  localparam logic signed [XYW-1:0] GAIN_Q30 = 33'sd652032874;

  localparam logic [23:0]        YAW_SPAN  = 24'd46080;
  localparam logic signed [24:0] YAW_HALF  = 25'sd23040;
  localparam logic signed [24:0] PITCH_LIM = 25'sd11392;

  // Configuration register indexes.
  localparam logic [2:0] REG_MOVE_SPEED = 3'd0;
  localparam logic [2:0] REG_TURN_SPEED = 3'd1;
  localparam logic [2:0] REG_WORLD_UP_X = 3'd2;
  localparam logic [2:0] REG_WORLD_UP_Y = 3'd3;
  localparam logic [2:0] REG_WORLD_UP_Z = 3'd4;

  typedef struct packed {
    logic                  start;
    logic signed [ZW-1:0]  z;
  } cordic_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [XYW-1:0] c;
    logic signed [XYW-1:0] s;
  } cordic_rsp_t;

  typedef struct packed {
    logic                  start;
    logic signed [NW-1:0]  n0;
    logic signed [NW-1:0]  n1;
    logic signed [NW-1:0]  n2;
    logic [L2W-1:0]        l2;
  } norm_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [VW-1:0]  v0;
    logic signed [VW-1:0]  v1;
    logic signed [VW-1:0]  v2;
  } norm_rsp_t;

  // Arctangent of 2^-i in degrees with 20 fraction bits.
  function automatic logic [26:0] atan_deg(input logic [4:0] idx);
    logic [26:0] v;
    case (idx)
      5'd0:  v = 27'd47185920;
      5'd1:  v = 27'd27855475;
      5'd2:  v = 27'd14718068;
      5'd3:  v = 27'd7471121;
      5'd4:  v = 27'd3750058;
      5'd5:  v = 27'd1876857;
      5'd6:  v = 27'd938658;
      5'd7:  v = 27'd469357;
      5'd8:  v = 27'd234682;
      5'd9:  v = 27'd117342;
      5'd10: v = 27'd58671;
      5'd11: v = 27'd29335;
      5'd12: v = 27'd14668;
      5'd13: v = 27'd7334;
      5'd14: v = 27'd3667;
      5'd15: v = 27'd1833;
      5'd16: v = 27'd917;
      5'd17: v = 27'd458;
      5'd18: v = 27'd229;
      5'd19: v = 27'd115;
      5'd20: v = 27'd57;
      5'd21: v = 27'd29;
      5'd22: v = 27'd14;
      5'd23: v = 27'd7;
      default: v = 27'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/ecu_if.sv */
`default_nettype none

// Input item channel.
interface ecu_item_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [5:0]         key_mask;
  logic [15:0]        delta_time;
  logic signed [15:0] x_change;
  logic signed [15:0] y_change;

  modport source (output valid, kind, key_mask, delta_time, x_change, y_change,
                  input ready);
  modport sink   (input valid, kind, key_mask, delta_time, x_change, y_change,
                  output ready);
endinterface

// Result channel.
interface ecu_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  logic signed [31:0] pos_z_out;
  logic signed [15:0] fwd_x_out;
  logic signed [15:0] fwd_y_out;
  logic signed [15:0] fwd_z_out;
  logic signed [15:0] up_x_out;
  logic signed [15:0] up_y_out;
  logic signed [15:0] up_z_out;
  logic signed [15:0] yaw_out;
  logic signed [14:0] pitch_out;

  modport source (output valid, pos_x_out, pos_y_out, pos_z_out, fwd_x_out, fwd_y_out,
                  fwd_z_out, up_x_out, up_y_out, up_z_out, yaw_out, pitch_out,
                  input ready);
  modport sink   (input valid, pos_x_out, pos_y_out, pos_z_out, fwd_x_out, fwd_y_out,
                  fwd_z_out, up_x_out, up_y_out, up_z_out, yaw_out, pitch_out,
                  output ready);
endinterface

`default_nettype wire

/* hdl/ecu_mul.sv */
`default_nettype none

// Shared signed multiplier with a registered product.
module ecu_mul (
  input  wire logic                                 clk,
  input  wire logic signed [ecu_pkg::XYW-1:0]       a,
  input  wire logic signed [ecu_pkg::XYW-1:0]       b,
  output logic signed      [2*ecu_pkg::XYW-1:0]     prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

/* hdl/ecu_cordic.sv */
`default_nettype none

// Iterative rotation-mode CORDIC in degrees, one micro-rotation per cycle.
module ecu_cordic #(
  parameter int ITER = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ecu_pkg::cordic_req_t req,
  output ecu_pkg::cordic_rsp_t      rsp
);

  logic signed [ecu_pkg::XYW-1:0] x;
  logic signed [ecu_pkg::XYW-1:0] y;
  logic signed [ecu_pkg::ZW-1:0]  z;
  logic                           neg;
  logic                           busy;
  logic                           done;
  logic [4:0]                     idx;

  logic signed [ecu_pkg::ZW-1:0]  z_fold;
  logic                           neg_fold;
  logic signed [ecu_pkg::XYW-1:0] dx;
  logic signed [ecu_pkg::XYW-1:0] dy;
  logic signed [ecu_pkg::ZW-1:0]  at;

  // Fold angles beyond a quarter turn back by a half turn.
  always_comb begin
    z_fold   = req.z;
    neg_fold = 1'b0;
    if (req.z > ecu_pkg::DEG90) begin
      z_fold   = req.z - ecu_pkg::DEG180;
      neg_fold = 1'b1;
    end else if (req.z < -ecu_pkg::DEG90) begin
      z_fold   = req.z + ecu_pkg::DEG180;
      neg_fold = 1'b1;
    end
  end

  always_comb begin
    dx = y >>> idx;
    dy = x >>> idx;
    at = $signed({3'b000, ecu_pkg::atan_deg(idx)});
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        idx  <= 5'd0;
      end else if (busy) begin
        idx <= idx + 5'd1;
        if (idx == 5'(ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Rotation datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      x   <= ecu_pkg::GAIN_Q30;
      y   <= '0;
      z   <= z_fold;
      neg <= neg_fold;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.c    = neg ? -x : x;
  assign rsp.s    = neg ? -y : y;

endmodule

`default_nettype wire

/* hdl/ecu_norm.sv */
`default_nettype none

// Normalizes a three-component vector to Q1.14: a bit-pair integer square
// root of the squared length, then a restoring divide for each component.
module ecu_norm (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ecu_pkg::norm_req_t req,
  output ecu_pkg::norm_rsp_t      rsp
);

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SQRT = 3'd1;
  localparam logic [2:0] N_DSET = 3'd2;
  localparam logic [2:0] N_DIV  = 3'd3;
  localparam logic [2:0] N_DST  = 3'd4;

  logic [2:0]                     st;
  logic                           done;
  logic [4:0]                     cnt;
  logic [1:0]                     comp;
  logic [ecu_pkg::L2W-1:0]        x;
  logic [ecu_pkg::L2W-1:0]        r;
  logic [ecu_pkg::L2W-1:0]        bm;
  logic [39:0]                    num;
  logic [39:0]                    den;
  logic [14:0]                    q;
  logic signed [ecu_pkg::NW-1:0]  nv [3];
  logic signed [ecu_pkg::VW-1:0]  res [3];

  logic [ecu_pkg::L2W-1:0]        trial;
  logic [ecu_pkg::LENW-1:0]       len;
  logic signed [ecu_pkg::NW-1:0]  ncur;
  logic [ecu_pkg::NW-1:0]         mag;
  logic signed [ecu_pkg::VW-1:0]  qv;

  always_comb begin
    trial = r + bm;
    len   = r[ecu_pkg::LENW-1:0];
    ncur  = nv[comp];
    mag   = (ncur < 0) ? ecu_pkg::NW'(-ncur) : ecu_pkg::NW'(ncur);
    qv    = $signed({1'b0, q});
    if (len == '0) begin
      qv = '0;
    end else if (ncur < 0) begin
      qv = -qv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= N_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        N_IDLE: begin
          if (req.start) begin
            nv[0] <= req.n0;
            nv[1] <= req.n1;
            nv[2] <= req.n2;
            x     <= req.l2;
            r     <= '0;
            bm    <= ecu_pkg::L2W'(1) << 46;
            cnt   <= 5'd0;
            st    <= N_SQRT;
          end
        end
        // One result bit of the square root per cycle.
        N_SQRT: begin
          if (x >= trial) begin
            x <= x - trial;
            r <= (r >> 1) + bm;
          end else begin
            r <= r >> 1;
          end
          bm  <= bm >> 2;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd23) begin
            comp <= 2'd0;
            st   <= N_DSET;
          end
        end
        // Rounded numerator and aligned divisor for this component.
        N_DSET: begin
          num <= {1'b0, mag, 14'd0} + 40'(len >> 1);
          den <= {1'b0, len, 14'd0};
          q   <= '0;
          cnt <= 5'd0;
          st  <= N_DIV;
        end
        // One quotient bit per cycle.
        N_DIV: begin
          if (num >= den) begin
            num <= num - den;
            q   <= {q[13:0], 1'b1};
          end else begin
            q   <= {q[13:0], 1'b0};
          end
          den <= den >> 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd14) begin
            st <= N_DST;
          end
        end
        N_DST: begin
          res[comp] <= qv;
          if (comp == 2'd2) begin
            done <= 1'b1;
            st   <= N_IDLE;
          end else begin
            comp <= comp + 2'd1;
            st   <= N_DSET;
          end
        end
        default: st <= N_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.v0   = res[0];
  assign rsp.v1   = res[1];
  assign rsp.v2   = res[2];

endmodule

`default_nettype wire

/* hdl/euler_camera_update.sv */
// Move item: the shared multiplier first forms the step, then takes one product
// per position component for each set key bit.
// Turn item: most of the time goes to the normalizer (24 square-root steps and
// 3 x 15 divide steps, three vectors).
// One item at a time; the next beat is accepted after the result is registered.
// Synchronous active-high reset: position, yaw, pitch zero, basis to identity.
`default_nettype none

module euler_camera_update #(
  parameter int CORDIC_STEPS  = 16,
  parameter int POS_FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  ecu_item_if.sink         item,
  ecu_result_if.source     result
);

  localparam int ITER = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int SH   = 38 - POS_FRAC_BITS;
  localparam int MW   = 2 * ecu_pkg::XYW;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_STEP  = 5'd1;
  localparam logic [4:0] S_STEPW = 5'd2;
  localparam logic [4:0] S_MV    = 5'd3;
  localparam logic [4:0] S_MVA   = 5'd4;
  localparam logic [4:0] S_T0    = 5'd5;
  localparam logic [4:0] S_T1    = 5'd6;
  localparam logic [4:0] S_T2    = 5'd7;
  localparam logic [4:0] S_MOD   = 5'd8;
  localparam logic [4:0] S_MODF  = 5'd9;
  localparam logic [4:0] S_CY    = 5'd10;
  localparam logic [4:0] S_CYW   = 5'd11;
  localparam logic [4:0] S_CP    = 5'd12;
  localparam logic [4:0] S_CPW   = 5'd13;
  localparam logic [4:0] S_F0    = 5'd14;
  localparam logic [4:0] S_F1    = 5'd15;
  localparam logic [4:0] S_F2    = 5'd16;
  localparam logic [4:0] S_RND   = 5'd17;
  localparam logic [4:0] S_SQ    = 5'd18;
  localparam logic [4:0] S_NS    = 5'd19;
  localparam logic [4:0] S_NW    = 5'd20;
  localparam logic [4:0] S_XM    = 5'd21;
  localparam logic [4:0] S_OUT   = 5'd22;

  function automatic logic [1:0] nxt(input logic [1:0] a);
    logic [1:0] v;
    case (a)
      2'd0:    v = 2'd1;
      2'd1:    v = 2'd2;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] prv(input logic [1:0] a);
    logic [1:0] v;
    case (a)
      2'd0:    v = 2'd2;
      2'd1:    v = 2'd0;
      default: v = 2'd1;
    endcase
    return v;
  endfunction

  // Configuration and architectural state.
  logic [15:0]                    move_speed;
  logic [15:0]                    turn_speed;
  logic signed [15:0]             wu [3];
  logic signed [31:0]             pos [3];
  logic signed [15:0]             yaw;
  logic signed [14:0]             pitch;
  logic signed [15:0]             fwd [3];
  logic signed [15:0]             rgt [3];
  logic signed [15:0]             upv [3];

  // Sequencer state and working registers.
  logic [4:0]                     state;
  logic                           rvalid;
  logic [5:0]                     keys;
  logic [15:0]                    dt;
  logic signed [15:0]             xc;
  logic signed [15:0]             yc;
  logic [31:0]                    step;
  logic [2:0]                     k;
  logic [1:0]                     j;
  logic [23:0]                    acc;
  logic                           vneg;
  logic [2:0]                     modk;
  logic signed [ecu_pkg::XYW-1:0] cy;
  logic signed [ecu_pkg::XYW-1:0] sy;
  logic signed [ecu_pkg::XYW-1:0] cp;
  logic signed [ecu_pkg::XYW-1:0] sp;
  logic signed [33:0]             src [3];
  logic signed [ecu_pkg::NW-1:0]  nreg [3];
  logic [ecu_pkg::L2W-1:0]        l2;
  logic [2:0]                     cnt;
  logic [1:0]                     phase;

  logic signed [ecu_pkg::XYW-1:0] ma;
  logic signed [ecu_pkg::XYW-1:0] mb;
  logic signed [MW-1:0]           prod;

  ecu_pkg::cordic_req_t           creq;
  ecu_pkg::cordic_rsp_t           crsp;
  ecu_pkg::norm_req_t             nreq;
  ecu_pkg::norm_rsp_t             nrsp;

  // Combinational helpers.
  logic signed [15:0]             vsel;
  logic                           minus;
  logic signed [MW-1:0]           mv_r;
  logic signed [33:0]             mv_d;
  logic signed [34:0]             mv_sum;
  logic signed [31:0]             mv_sat;
  logic signed [MW-1:0]           t_r;
  logic signed [24:0]             t_v;
  logic signed [24:0]             t_p;
  logic [23:0]                    mod_sub;
  logic [23:0]                    mod_m;
  logic signed [MW-1:0]           f_sh;
  logic signed [33:0]             rnd_v [3];
  logic [1:0]                     jj;
  logic [1:0]                     ia;
  logic [1:0]                     ib;
  logic signed [15:0]             xa;
  logic signed [15:0]             xb;
  logic [2:0]                     cm;

  ecu_mul u_mul (
    .clk  (clk),
    .a    (ma),
    .b    (mb),
    .prod (prod)
  );

  ecu_cordic #(.ITER(ITER)) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  ecu_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (nreq),
    .rsp (nrsp)
  );

  // Move: vector for the current key and the rounded, saturated position update.
  always_comb begin
    case (k)
      3'd0, 3'd1: vsel = fwd[j];
      3'd2, 3'd3: vsel = rgt[j];
      default:    vsel = wu[j];
    endcase
    minus  = (k == 3'd1) || (k == 3'd2) || (k == 3'd4);
    mv_r   = (prod + (MW'(1) <<< (SH - 1))) >>> SH;
    mv_d   = mv_r[33:0];
    if (minus) begin
      mv_d = -mv_d;
    end
    mv_sum = {{3{pos[j][31]}}, pos[j]} + {mv_d[33], mv_d};
    if (mv_sum > 35'sd2147483647) begin
      mv_sat = 32'sh7FFFFFFF;
    end else if (mv_sum < -35'sd2147483648) begin
      mv_sat = 32'sh80000000;
    end else begin
      mv_sat = mv_sum[31:0];
    end
  end

  // Turn: rounded mouse products, wrapped yaw and clamped pitch.
  always_comb begin
    t_r     = (prod + MW'(256)) >>> 9;
    t_v     = {{9{yaw[15]}}, yaw} + {t_r[23], t_r[23:0]} + ecu_pkg::YAW_HALF;
    t_p     = {{10{pitch[14]}}, pitch} + {t_r[23], t_r[23:0]};
    mod_sub = ecu_pkg::YAW_SPAN << modk;
    mod_m   = (vneg && (acc != '0)) ? (ecu_pkg::YAW_SPAN - acc) : acc;
    f_sh    = prod >>> 30;
  end

  // Rounding of the vector that is about to be normalized.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (phase == 2'd0) begin
        rnd_v[i] = (src[i] + 34'sd512) >>> 10;
      end else begin
        rnd_v[i] = (src[i] + 34'sd128) >>> 8;
      end
    end
  end

  // Cross product operand selection: two products per component.
  always_comb begin
    jj = cnt[2:1];
    ia = cnt[0] ? prv(jj) : nxt(jj);
    ib = cnt[0] ? nxt(jj) : prv(jj);
    xa = (phase == 2'd1) ? fwd[ia] : rgt[ia];
    xb = (phase == 2'd1) ? wu[ib]  : fwd[ib];
    cm = cnt - 3'd1;
  end

  // Shared multiplier operands.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_STEP: begin
        ma = {17'd0, move_speed};
        mb = {17'd0, dt};
      end
      S_MV: begin
        ma = {{17{vsel[15]}}, vsel};
        mb = {1'b0, step};
      end
      S_T0: begin
        ma = {{17{xc[15]}}, xc};
        mb = {17'd0, turn_speed};
      end
      S_T1: begin
        ma = {{17{yc[15]}}, yc};
        mb = {17'd0, turn_speed};
      end
      S_F0: begin
        ma = cy;
        mb = cp;
      end
      S_F1: begin
        ma = sy;
        mb = cp;
      end
      S_SQ: begin
        if (cnt != 3'd3) begin
          ma = {{8{nreg[cnt[1:0]][ecu_pkg::NW-1]}}, nreg[cnt[1:0]]};
          mb = ma;
        end
      end
      S_XM: begin
        if (cnt != 3'd6) begin
          ma = {{17{xa[15]}}, xa};
          mb = {{17{xb[15]}}, xb};
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Unit requests.
  always_comb begin
    creq.start = (state == S_CY) || (state == S_CP);
    creq.z     = (state == S_CY) ? $signed({yaw[15], yaw, 13'd0})
                                 : $signed({{2{pitch[14]}}, pitch, 13'd0});
    nreq.start = (state == S_NS);
    nreq.n0    = nreg[0];
    nreq.n1    = nreg[1];
    nreq.n2    = nreg[2];
    nreq.l2    = l2;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed <= 16'd256;
      turn_speed <= 16'd4096;
      wu[0]      <= 16'sd0;
      wu[1]      <= 16'sd16384;
      wu[2]      <= 16'sd0;
    end else if (cfg_write) begin
      case (cfg_index)
        ecu_pkg::REG_MOVE_SPEED: move_speed <= cfg_data;
        ecu_pkg::REG_TURN_SPEED: turn_speed <= cfg_data;
        ecu_pkg::REG_WORLD_UP_X: wu[0]      <= $signed(cfg_data);
        ecu_pkg::REG_WORLD_UP_Y: wu[1]      <= $signed(cfg_data);
        ecu_pkg::REG_WORLD_UP_Z: wu[2]      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rvalid <= 1'b0;
      yaw    <= '0;
      pitch  <= '0;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
      end
      fwd[0] <= 16'sd16384;
      fwd[1] <= 16'sd0;
      fwd[2] <= 16'sd0;
      rgt[0] <= 16'sd0;
      rgt[1] <= 16'sd0;
      rgt[2] <= 16'sd16384;
      upv[0] <= 16'sd0;
      upv[1] <= 16'sd16384;
      upv[2] <= 16'sd0;
    end else begin
      if (rvalid && result.ready && (state != S_OUT)) begin
        rvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            keys  <= item.key_mask;
            dt    <= item.delta_time;
            xc    <= item.x_change;
            yc    <= item.y_change;
            state <= item.kind ? S_T0 : S_STEP;
          end
        end
        S_STEP: state <= S_STEPW;
        S_STEPW: begin
          step  <= prod[31:0];
          k     <= 3'd0;
          j     <= 2'd0;
          state <= S_MV;
        end
        // Walk the key bits; each set key takes one product per component.
        S_MV: begin
          if (keys[k]) begin
            state <= S_MVA;
          end else if (k == 3'd5) begin
            state <= S_OUT;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_MVA: begin
          pos[j] <= mv_sat;
          if (j == 2'd2) begin
            j <= 2'd0;
            if (k == 3'd5) begin
              state <= S_OUT;
            end else begin
              k     <= k + 3'd1;
              state <= S_MV;
            end
          end else begin
            j     <= j + 2'd1;
            state <= S_MV;
          end
        end
        S_T0: state <= S_T1;
        S_T1: begin
          vneg  <= t_v < 0;
          acc   <= (t_v < 0) ? 24'(-t_v) : 24'(t_v);
          state <= S_T2;
        end
        S_T2: begin
          if (t_p > ecu_pkg::PITCH_LIM) begin
            pitch <= 15'(ecu_pkg::PITCH_LIM);
          end else if (t_p < -ecu_pkg::PITCH_LIM) begin
            pitch <= 15'(-ecu_pkg::PITCH_LIM);
          end else begin
            pitch <= t_p[14:0];
          end
          modk  <= 3'd7;
          state <= S_MOD;
        end
        // Yaw remainder by conditional subtraction of shifted full turns.
        S_MOD: begin
          if (acc >= mod_sub) begin
            acc <= acc - mod_sub;
          end
          if (modk == 3'd0) begin
            state <= S_MODF;
          end else begin
            modk <= modk - 3'd1;
          end
        end
        S_MODF: begin
          yaw   <= 16'(mod_m - 24'd23040);
          state <= S_CY;
        end
        S_CY: state <= S_CYW;
        S_CYW: begin
          if (crsp.done) begin
            cy    <= crsp.c;
            sy    <= crsp.s;
            state <= S_CP;
          end
        end
        S_CP: state <= S_CPW;
        S_CPW: begin
          if (crsp.done) begin
            cp    <= crsp.c;
            sp    <= crsp.s;
            state <= S_F0;
          end
        end
        S_F0: state <= S_F1;
        S_F1: begin
          src[0] <= f_sh[33:0];
          state  <= S_F2;
        end
        S_F2: begin
          src[2] <= f_sh[33:0];
          src[1] <= {sp[32], sp};
          phase  <= 2'd0;
          state  <= S_RND;
        end
        S_RND: begin
          for (int i = 0; i < 3; i++) begin
            nreg[i] <= rnd_v[i][ecu_pkg::NW-1:0];
          end
          cnt   <= 3'd0;
          l2    <= '0;
          state <= S_SQ;
        end
        // Squared length, one square per cycle.
        S_SQ: begin
          if (cnt != 3'd0) begin
            l2 <= l2 + prod[ecu_pkg::L2W-1:0];
          end
          if (cnt == 3'd3) begin
            state <= S_NS;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_NS: state <= S_NW;
        S_NW: begin
          if (nrsp.done) begin
            cnt <= 3'd0;
            case (phase)
              2'd0: begin
                fwd[0] <= nrsp.v0;
                fwd[1] <= nrsp.v1;
                fwd[2] <= nrsp.v2;
                phase  <= 2'd1;
                state  <= S_XM;
              end
              2'd1: begin
                rgt[0] <= nrsp.v0;
                rgt[1] <= nrsp.v1;
                rgt[2] <= nrsp.v2;
                phase  <= 2'd2;
                state  <= S_XM;
              end
              default: begin
                upv[0] <= nrsp.v0;
                upv[1] <= nrsp.v1;
                upv[2] <= nrsp.v2;
                state  <= S_OUT;
              end
            endcase
          end
        end
        // Cross product: first product of a component is stored, second subtracted.
        S_XM: begin
          if (cnt != 3'd0) begin
            if (cm[0]) begin
              src[cm[2:1]] <= src[cm[2:1]] - prod[33:0];
            end else begin
              src[cm[2:1]] <= prod[33:0];
            end
          end
          if (cnt == 3'd6) begin
            state <= S_RND;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        // Load the result register once the previous beat has gone.
        S_OUT: begin
          if (!rvalid || result.ready) begin
            result.pos_x_out <= pos[0];
            result.pos_y_out <= pos[1];
            result.pos_z_out <= pos[2];
            result.fwd_x_out <= fwd[0];
            result.fwd_y_out <= fwd[1];
            result.fwd_z_out <= fwd[2];
            result.up_x_out  <= upv[0];
            result.up_y_out  <= upv[1];
            result.up_z_out  <= upv[2];
            result.yaw_out   <= yaw;
            result.pitch_out <= pitch;
            rvalid           <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item.ready   = (state == S_IDLE);
  assign result.valid = rvalid;

endmodule

`default_nettype wire
